/* design/bcl_pkg.sv */
package bcl_pkg;

  localparam int SIDE      = 256;
  localparam int WORD_BITS = 32;
  localparam int ROW_WORDS = SIDE / WORD_BITS;
  localparam int MEM_DEPTH = SIDE * ROW_WORDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CW        = $clog2(SIDE);
  localparam int WSEL_W    = 3;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int POS_W     = CW + 3;
  localparam int ERR_W     = 2 * CW + 3;
  localparam int IN_W      = 48;
  localparam int RBIT_W    = $clog2(CW);

  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_CIRCLE,
    KIND_READ,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLR_STEP,
    CMD_LINE_INIT,
    CMD_OUTER,
    CMD_PIX_RD,
    CMD_PIX_WR,
    CMD_MIN_STEP,
    CMD_SPAN_RD,
    CMD_SPAN_WR,
    CMD_COL_INIT,
    CMD_COL_SQ,
    CMD_COL_V,
    CMD_ROOT_STEP,
    CMD_ROOT_RND,
    CMD_COL_SPAN,
    CMD_COL_NEXT,
    CMD_READ_RD,
    CMD_READ_CAP,
    CMD_RESULT
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_WIPE,
    ST_IDLE,
    ST_DISPATCH,
    ST_LINE_INIT,
    ST_OUTER,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_MIN_STEP,
    ST_SPAN_CHK,
    ST_SPAN_RD,
    ST_SPAN_WR,
    ST_COL_INIT,
    ST_COL_CHK,
    ST_COL_SQ,
    ST_COL_V,
    ST_ROOT,
    ST_ROOT_RND,
    ST_COL_SPAN,
    ST_COL_NEXT,
    ST_READ_RD,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  is_span;
    logic  inner_again;
    logic  outer_again;
    logic  span_done;
    logic  col_done;
    logic  col_skip;
    logic  root_last;
  } status_t;

endpackage

/* design/bcl_ram.sv */
module bcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/bcl_ctrl.sv */
module bcl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bcl_pkg::status_t status,
  output bcl_pkg::cmd_t    cmd
);
  import bcl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:       if (status.clr_last) state_nxt = ST_IDLE;
      ST_WIPE:      if (status.clr_last) state_nxt = ST_DONE;
      ST_IDLE:      if (in_tvalid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status.kind)
          KIND_LINE:   state_nxt = ST_LINE_INIT;
          KIND_CIRCLE: state_nxt = ST_COL_INIT;
          KIND_READ:   state_nxt = ST_READ_RD;
          default:     state_nxt = ST_WIPE;
        endcase
      end
      ST_LINE_INIT: state_nxt = status.is_span ? ST_SPAN_CHK : ST_OUTER;
      ST_OUTER:     state_nxt = ST_PIX_RD;
      ST_PIX_RD:    state_nxt = ST_PIX_WR;
      ST_PIX_WR:    state_nxt = status.inner_again ? ST_PIX_RD : ST_MIN_STEP;
      ST_MIN_STEP:  state_nxt = status.outer_again ? ST_OUTER : ST_DONE;
      ST_SPAN_CHK: begin
        if (!status.span_done) begin
          state_nxt = ST_SPAN_RD;
        end else if (status.kind == KIND_CIRCLE) begin
          state_nxt = ST_COL_NEXT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SPAN_RD:   state_nxt = ST_SPAN_WR;
      ST_SPAN_WR:   state_nxt = ST_SPAN_CHK;
      ST_COL_INIT:  state_nxt = ST_COL_CHK;
      ST_COL_CHK: begin
        if (status.col_done) begin
          state_nxt = ST_DONE;
        end else if (status.col_skip) begin
          state_nxt = ST_COL_NEXT;
        end else begin
          state_nxt = ST_COL_SQ;
        end
      end
      ST_COL_SQ:    state_nxt = ST_COL_V;
      ST_COL_V:     state_nxt = ST_ROOT;
      ST_ROOT:      if (status.root_last) state_nxt = ST_ROOT_RND;
      ST_ROOT_RND:  state_nxt = ST_COL_SPAN;
      ST_COL_SPAN:  state_nxt = ST_SPAN_CHK;
      ST_COL_NEXT:  state_nxt = ST_COL_CHK;
      ST_READ_RD:   state_nxt = ST_READ_CAP;
      ST_READ_CAP:  state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_CLR, ST_WIPE: cmd = CMD_CLR_STEP;
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = CMD_LOAD;
      end
      ST_LINE_INIT: cmd = CMD_LINE_INIT;
      ST_OUTER:     cmd = CMD_OUTER;
      ST_PIX_RD:    cmd = CMD_PIX_RD;
      ST_PIX_WR:    cmd = CMD_PIX_WR;
      ST_MIN_STEP:  cmd = CMD_MIN_STEP;
      ST_SPAN_RD:   cmd = CMD_SPAN_RD;
      ST_SPAN_WR:   cmd = CMD_SPAN_WR;
      ST_COL_INIT:  cmd = CMD_COL_INIT;
      ST_COL_SQ:    cmd = CMD_COL_SQ;
      ST_COL_V:     cmd = CMD_COL_V;
      ST_ROOT:      cmd = CMD_ROOT_STEP;
      ST_ROOT_RND:  cmd = CMD_ROOT_RND;
      ST_COL_SPAN:  cmd = CMD_COL_SPAN;
      ST_COL_NEXT:  cmd = CMD_COL_NEXT;
      ST_READ_RD:   cmd = CMD_READ_RD;
      ST_READ_CAP:  cmd = CMD_READ_CAP;
      ST_DONE:      if (out_free) cmd = CMD_RESULT;
      default:      cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLR)
    else $error("reset did not start the clearing sweep");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_DISPATCH)
    else $error("accepted command was not dispatched");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished command did not post its result");

endmodule

/* design/bcl_datapath.sv */
module bcl_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcl_pkg::cmd_t                cmd,
  input  bcl_pkg::kind_t               in_kind,
  input  logic [bcl_pkg::IN_W-1:0]     in_data,
  output bcl_pkg::status_t             status,
  output logic [bcl_pkg::WORD_BITS-1:0] out_data
);
  import bcl_pkg::*;

  kind_t                kind_r;
  logic [CW-1:0]        fa_r, sa_r, fb_r, sb_r, rad_r;
  logic [WSEL_W-1:0]    ws_r;

  logic [ADDR_W-1:0]    clr_cnt_r;

  logic signed [POS_W-1:0] pa_r, pb_r;
  logic                 bmaj_r, smaj_neg_r, smin_neg_r;
  logic [CW-1:0]        dmaj_r, dmin_r;
  logic signed [ERR_W-1:0] e_in_r, e_out_r;

  logic                 sp_axis_r;
  logic [CW-1:0]        sp_fix_r;
  logic [CW:0]          sp_cur_r, sp_hi_r;

  logic signed [POS_W-1:0] c_r, cend_r;
  logic [2*CW-1:0]      rr_r, dd_r, v_r;
  logic [CW:0]          s_r;
  logic [RBIT_W-1:0]    bit_r;

  logic [WORD_BITS-1:0] res_r, out_data_r;

  // Decoded command fields.
  logic signed [POS_W-1:0] fa_s, sa_s, fb_s, sb_s, rad_s;
  logic signed [POS_W-1:0] d_a, d_b, d_c, lo_c, hi_c;
  logic [CW-1:0]        abs_a, abs_b, abs_c;
  logic [2*CW-1:0]      prod_ab;
  logic signed [ERR_W-1:0] dmaj_e, dmin_e, e_in_dec;
  logic signed [POS_W-1:0] step_maj, step_min;
  logic [CW-1:0]        root_t;
  logic [2*CW-1:0]      root_tt, root_ss, root_rem;

  // Pixel addressing and memory port.
  logic                 use_span;
  logic signed [POS_W-1:0] px_a, px_b;
  logic                 px_inside;
  logic [ADDR_W-1:0]    px_addr;
  logic [WORD_BITS-1:0] px_mask;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  assign fa_s  = $signed({{(POS_W-CW){1'b0}}, fa_r});
  assign sa_s  = $signed({{(POS_W-CW){1'b0}}, sa_r});
  assign fb_s  = $signed({{(POS_W-CW){1'b0}}, fb_r});
  assign sb_s  = $signed({{(POS_W-CW){1'b0}}, sb_r});
  assign rad_s = $signed({{(POS_W-CW){1'b0}}, rad_r});

  assign d_a   = fb_s - fa_s;
  assign d_b   = sb_s - sa_s;
  assign abs_a = d_a[POS_W-1] ? CW'(-d_a) : CW'(d_a);
  assign abs_b = d_b[POS_W-1] ? CW'(-d_b) : CW'(d_b);
  assign prod_ab = abs_a * abs_b;

  assign dmaj_e   = $signed({{(ERR_W-CW){1'b0}}, dmaj_r});
  assign dmin_e   = $signed({{(ERR_W-CW){1'b0}}, dmin_r});
  assign e_in_dec = e_in_r - dmin_e;
  assign step_maj = smaj_neg_r ? -POS_W'(1) : POS_W'(1);
  assign step_min = smin_neg_r ? -POS_W'(1) : POS_W'(1);

  assign d_c   = c_r - sa_s;
  assign abs_c = d_c[POS_W-1] ? CW'(-d_c) : CW'(d_c);

  assign root_t   = s_r[CW-1:0] | (CW'(1) << bit_r);
  assign root_tt  = root_t * root_t;
  assign root_ss  = s_r[CW-1:0] * s_r[CW-1:0];
  assign root_rem = v_r - root_ss;

  assign lo_c = fa_s - $signed({{(POS_W-CW-1){1'b0}}, s_r});
  assign hi_c = fa_s + $signed({{(POS_W-CW-1){1'b0}}, s_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd == CMD_CLR_STEP) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        kind_r <= in_kind;
        fa_r   <= in_data[CW-1:0];
        sa_r   <= in_data[2*CW-1:CW];
        fb_r   <= in_data[3*CW-1:2*CW];
        sb_r   <= in_data[4*CW-1:3*CW];
        rad_r  <= in_data[5*CW-1:4*CW];
        ws_r   <= in_data[5*CW+WSEL_W-1:5*CW];
        res_r  <= '0;
      end
      CMD_LINE_INIT: begin
        pa_r    <= fa_s;
        pb_r    <= sa_s;
        bmaj_r  <= abs_a < abs_b;
        e_in_r  <= $signed({{(ERR_W-2*CW){1'b0}}, prod_ab});
        e_out_r <= $signed({{(ERR_W-2*CW){1'b0}}, prod_ab});
        if (abs_a < abs_b) begin
          dmaj_r     <= abs_b;
          dmin_r     <= abs_a;
          smaj_neg_r <= d_b[POS_W-1];
          smin_neg_r <= d_a[POS_W-1];
        end else begin
          dmaj_r     <= abs_a;
          dmin_r     <= abs_b;
          smaj_neg_r <= d_a[POS_W-1];
          smin_neg_r <= d_b[POS_W-1];
        end
        // Axis-aligned lines are drawn as inclusive spans.
        if (fa_r == fb_r) begin
          sp_axis_r <= 1'b1;
          sp_fix_r  <= fa_r;
          sp_cur_r  <= {1'b0, (sa_r < sb_r) ? sa_r : sb_r};
          sp_hi_r   <= {1'b0, (sa_r < sb_r) ? sb_r : sa_r};
        end else begin
          sp_axis_r <= 1'b0;
          sp_fix_r  <= sa_r;
          sp_cur_r  <= {1'b0, (fa_r < fb_r) ? fa_r : fb_r};
          sp_hi_r   <= {1'b0, (fa_r < fb_r) ? fb_r : fa_r};
        end
      end
      CMD_OUTER: e_out_r <= e_out_r - dmaj_e;
      CMD_PIX_WR: begin
        e_in_r <= e_in_dec;
        if (bmaj_r) pb_r <= pb_r + step_maj;
        else        pa_r <= pa_r + step_maj;
      end
      CMD_MIN_STEP: begin
        if (bmaj_r) pa_r <= pa_r + step_min;
        else        pb_r <= pb_r + step_min;
      end
      CMD_SPAN_WR: sp_cur_r <= sp_cur_r + (CW+1)'(1);
      CMD_COL_INIT: begin
        c_r    <= sa_s - rad_s;
        cend_r <= sa_s + rad_s;
        rr_r   <= rad_r * rad_r;
      end
      CMD_COL_SQ: dd_r <= abs_c * abs_c;
      CMD_COL_V: begin
        v_r   <= rr_r - dd_r;
        s_r   <= '0;
        bit_r <= RBIT_W'(CW - 1);
      end
      CMD_ROOT_STEP: begin
        if (root_tt <= v_r) s_r <= {1'b0, root_t};
        bit_r <= bit_r - RBIT_W'(1);
      end
      CMD_ROOT_RND: begin
        if (root_rem > {{(CW-1){1'b0}}, s_r}) s_r <= s_r + (CW+1)'(1);
      end
      CMD_COL_SPAN: begin
        sp_axis_r <= 1'b0;
        sp_fix_r  <= c_r[CW-1:0];
        sp_cur_r  <= lo_c[POS_W-1] ? '0 : lo_c[CW:0];
        sp_hi_r   <= (hi_c > POS_W'(SIDE - 1)) ? (CW+1)'(SIDE - 1) : hi_c[CW:0];
      end
      CMD_COL_NEXT: c_r <= c_r + POS_W'(1);
      CMD_READ_CAP: res_r <= mem_rdata;
      CMD_RESULT:   out_data_r <= res_r;
      default: ;
    endcase
  end

  assign use_span = (cmd == CMD_SPAN_RD) || (cmd == CMD_SPAN_WR);

  always_comb begin
    px_a = pa_r;
    px_b = pb_r;
    if (use_span) begin
      if (sp_axis_r) begin
        px_a = $signed({{(POS_W-CW){1'b0}}, sp_fix_r});
        px_b = $signed({{(POS_W-CW-1){1'b0}}, sp_cur_r});
      end else begin
        px_a = $signed({{(POS_W-CW-1){1'b0}}, sp_cur_r});
        px_b = $signed({{(POS_W-CW){1'b0}}, sp_fix_r});
      end
    end
  end

  assign px_inside = !px_a[POS_W-1] && !px_b[POS_W-1] &&
                     (px_a < POS_W'(SIDE)) && (px_b < POS_W'(SIDE));
  assign px_addr   = {px_a[CW-1:0], px_b[CW-1:BIT_W]};
  assign px_mask   = WORD_BITS'(1) << px_b[BIT_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = px_addr;
    mem_wdata = mem_rdata | px_mask;
    case (cmd)
      CMD_CLR_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      CMD_PIX_WR, CMD_SPAN_WR: mem_we = px_inside;
      default: mem_we = 1'b0;
    endcase
  end

  assign mem_re    = (cmd == CMD_PIX_RD) || (cmd == CMD_SPAN_RD) || (cmd == CMD_READ_RD);
  assign mem_raddr = (cmd == CMD_READ_RD) ? {fa_r, ws_r} : px_addr;

  bcl_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_bitmap (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    status.kind        = kind_r;
    status.clr_last    = &clr_cnt_r;
    status.is_span     = (fa_r == fb_r) || (sa_r == sb_r);
    status.inner_again = e_in_dec >= e_out_r;
    status.outer_again = e_out_r > 0;
    status.span_done   = sp_cur_r > sp_hi_r;
    status.col_done    = c_r > cend_r;
    status.col_skip    = c_r[POS_W-1] || (c_r > POS_W'(SIDE - 1));
    status.root_last   = bit_r == '0;
  end

  assign out_data = out_data_r;

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_CLR_STEP) |-> (mem_we && mem_wdata == '0))
    else $error("clearing sweep did not write a zero word");

  a_write_by_command: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cmd == CMD_CLR_STEP || cmd == CMD_PIX_WR || cmd == CMD_SPAN_WR))
    else $error("bitmap written outside a write command");

  a_span_on_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SPAN_WR) |-> px_inside)
    else $error("span pixel fell outside the bitmap");

endmodule

/* design/bitmap_circle_and_line_raster.sv */
// Bitmap rasterizer: keeps a one-bit 256 by 256 image and executes one
// command per input transaction on the in_ stream. The command kind travels
// in in_tuser and its operands in in_tdata. Every command, whatever its kind,
// produces exactly one output transaction on the out_ stream: the selected
// bitmap word for a read, and zero for line, circle and clear commands.
// Commands are processed one at a time; the bitmap lives in a RAM of 2048
// words of 32 bits with one read and one write port, and every pixel update
// is a read followed by a write, so that memory sets the pace.
// A read fetches and captures the selected word; the block returns to idle
// as the result is posted. A clear sweeps every word to zero, one word per
// cycle. A sloped line reads and writes each pixel in turn, with an extra
// step per minor-axis move; a straight line is a span with a check, a read
// and a write per pixel. A circle squares the offset of each column on the
// bitmap, takes an integer square root bit by bit with rounding and fills
// that span, skipping columns off the bitmap. After reset the block sweeps
// the whole bitmap to zero with in_tready low. The result sits in an output
// register, so the next command is accepted even while a result waits; a
// stalled receiver only holds the block when another result is to be posted.
module bitmap_circle_and_line_raster (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: first_a[7:0], second_a[15:8], first_b[23:16],
  // second_b[31:24], radius[39:32], word_select[42:40], zero fill.
  input  logic [47:0] in_tdata,
  // Fields from bit 0: kind[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: pixel_word[31:0].
  output logic [31:0] out_tdata
);
  import bcl_pkg::*;

  status_t status;
  cmd_t    cmd;
  kind_t   in_kind;

  assign in_kind = kind_t'(in_tuser);

  // The controller sequences each command; the datapath holds the operands,
  // the line and circle stepping registers and the bitmap memory.
  bcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bcl_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_kind (in_kind),
    .in_data (in_tdata),
    .status  (status),
    .out_data(out_tdata)
  );

endmodule
